// ===== hw/rtl/ring_angle_shader_unit_defines.svh =====
// Assertion macros shared by the ring angle shader RTL.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef RING_ANGLE_SHADER_UNIT_DEFINES_SVH
`define RING_ANGLE_SHADER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RASH_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rash assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RASH_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rash assertion failed");

`endif

// ===== hw/rtl/rash_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ring angle shader.
// No dependencies; used by rash_cordic and ring_angle_shader_unit.
package rash_pkg;

	localparam int TABLE_LEN = 24;
	localparam int ANGLE_W = 32;
	localparam int VEC_W = 46;
	localparam int COLOR_W = 16;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_INDEX_W = 3;

	localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

	// Arctangent of 2^-i as a fraction of a full turn.
	localparam logic [ANGLE_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CENTER_X     = 3'd0,
		REG_CENTER_Y     = 3'd1,
		REG_INNER_RADIUS = 3'd2,
		REG_OUTER_RADIUS = 3'd3,
		REG_START_ANGLE  = 3'd4,
		REG_SHADE_MODE   = 3'd5,
		REG_SOLID_COLOR  = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		SHADE_SOLID = 1'b0,
		SHADE_ANGLE = 1'b1
	} shade_mode_t;

	typedef struct packed {
		logic               hit;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} side_t;

endpackage

// ===== hw/rtl/rash_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined CORDIC: rotation by minus the start angle, then vectoring to a gray level.
// Depends on rash_pkg; stage enables come from the top level's pipeline control.
module rash_cordic #(
	parameter int CORDIC_STAGES = 16,
	parameter int COORD_BITS = 16,
	localparam int NST = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES,
	localparam int CB = (COORD_BITS < 16) ? COORD_BITS : 16,
	localparam int CS = 2 * NST + 3
) (
	input  logic                 clk,
	input  logic [CS-1:0]        en,
	input  logic signed [CB:0]   dx,
	input  logic signed [CB:0]   dy,
	input  logic [15:0]          start_angle,
	output logic [15:0]          gray
);
	import rash_pkg::*;

	localparam int GS = 40 - COORD_BITS;

	logic signed [VEC_W-1:0] x_s [CS-1];
	logic signed [VEC_W-1:0] y_s [CS-1];
	logic [ANGLE_W-1:0]      z_s [CS-1];
	logic [15:0]             gray_s;

	logic signed [VEC_W-1:0] x0;
	logic signed [VEC_W-1:0] y0;
	logic [ANGLE_W-1:0]      z0;
	logic [ANGLE_W-1:0]      acc_fin;
	logic [ANGLE_W-1:0]      mag_fin;
	logic [16:0]             g_fin;

	always_comb begin
		x0 = VEC_W'(dx) <<< GS;
		y0 = VEC_W'(dy) <<< GS;
		z0 = ANGLE_W'(0) - {start_angle, 16'h0000};
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			if (z0 > QUARTER_TURN && z0 < THREE_QUARTER_TURN) begin
				x_s[0] <= -x0;
				y_s[0] <= -y0;
				z_s[0] <= z0 - HALF_TURN;
			end else begin
				x_s[0] <= x0;
				y_s[0] <= y0;
				z_s[0] <= z0;
			end
		end
	end

	for (genvar i = 0; i < NST; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				if (!z_s[i][ANGLE_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_TURNS[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_TURNS[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST+1]) begin
			if (x_s[NST][VEC_W-1]) begin
				x_s[NST+1] <= -x_s[NST];
				y_s[NST+1] <= -y_s[NST];
				z_s[NST+1] <= HALF_TURN;
			end else begin
				x_s[NST+1] <= x_s[NST];
				y_s[NST+1] <= y_s[NST];
				z_s[NST+1] <= '0;
			end
		end
	end

	for (genvar j = 0; j < NST; j++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en[NST+2+j]) begin
				if (!y_s[NST+1+j][VEC_W-1]) begin
					x_s[NST+2+j] <= x_s[NST+1+j] + (y_s[NST+1+j] >>> j);
					y_s[NST+2+j] <= y_s[NST+1+j] - (x_s[NST+1+j] >>> j);
					z_s[NST+2+j] <= z_s[NST+1+j] + ATAN_TURNS[j];
				end else begin
					x_s[NST+2+j] <= x_s[NST+1+j] - (y_s[NST+1+j] >>> j);
					y_s[NST+2+j] <= y_s[NST+1+j] + (x_s[NST+1+j] >>> j);
					z_s[NST+2+j] <= z_s[NST+1+j] - ATAN_TURNS[j];
				end
			end
		end
	end

	always_comb begin
		acc_fin = z_s[2*NST+1];
		mag_fin = (acc_fin > HALF_TURN) ? (ANGLE_W'(0) - acc_fin) : acc_fin;
		g_fin = mag_fin[31:15];
	end

	always_ff @(posedge clk) begin
		if (en[CS-1]) begin
			gray_s <= g_fin[16] ? 16'hFFFF : g_fin[15:0];
		end
	end

	assign gray = gray_s;

endmodule

// ===== hw/rtl/ring_angle_shader_unit.sv =====
`timescale 1ns / 1ps
// Ring shader with conic angle gradient, with one register stage per CORDIC iteration.
// Throughput is one pixel per cycle while out_stall is low; each stage holds its item
// only while the next one is full and stalled, so bubbles close up under output stall.
// Reset clears all valid bits and loads the documented configuration defaults.
// Depends on rash_pkg, rash_cordic and ring_angle_shader_unit_defines.svh.
module ring_angle_shader_unit #(
	parameter int CORDIC_STAGES = 16,
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] x_coord,
	input  logic [15:0] y_coord,
	input  logic [15:0] background_red,
	input  logic [15:0] background_green,
	input  logic [15:0] background_blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ring_hit,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue
);
	import rash_pkg::*;
`include "ring_angle_shader_unit_defines.svh"

	localparam int NST = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
	localparam int CB = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam int CS = 2 * NST + 3;
	localparam int D = CS + 2;

	logic [15:0]         center_x_q;
	logic [15:0]         center_y_q;
	logic [15:0]         inner_radius_q;
	logic [15:0]         outer_radius_q;
	logic [15:0]         start_angle_q;
	shade_mode_t         shade_mode_q;
	logic [47:0]         solid_color_q;
	logic [2*CB-1:0]     ri_sq_q;
	logic [2*CB-1:0]     ro_sq_q;

	logic [D:1]          v_q;
	logic [D:1]          v_in;
	logic [D:1]          en_w;

	logic signed [CB:0]  dx_s1;
	logic signed [CB:0]  dy_s1;
	logic signed [2*CB+1:0] dx_prod;
	logic signed [2*CB+1:0] dy_prod;
	logic [2*CB:0]       dxsq_s2;
	logic [2*CB:0]       dysq_s2;
	logic [2*CB+1:0]     d2;
	side_t               side_s [1:D-1];
	logic [15:0]         gray;

	logic                ring_hit_q;
	logic [15:0]         out_red_q;
	logic [15:0]         out_green_q;
	logic [15:0]         out_blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= 16'd32768;
			center_y_q <= 16'd32768;
			inner_radius_q <= 16'd26214;
			outer_radius_q <= 16'd26870;
			start_angle_q <= 16'd8192;
			shade_mode_q <= SHADE_ANGLE;
			solid_color_q <= 48'hFFFF_0000_0000;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X: begin
					center_x_q <= cfg_wdata[15:0];
				end
				REG_CENTER_Y: begin
					center_y_q <= cfg_wdata[15:0];
				end
				REG_INNER_RADIUS: begin
					inner_radius_q <= cfg_wdata[15:0];
				end
				REG_OUTER_RADIUS: begin
					outer_radius_q <= cfg_wdata[15:0];
				end
				REG_START_ANGLE: begin
					start_angle_q <= cfg_wdata[15:0];
				end
				REG_SHADE_MODE: begin
					shade_mode_q <= shade_mode_t'(cfg_wdata[0]);
				end
				REG_SOLID_COLOR: begin
					solid_color_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ri_sq_q <= inner_radius_q[CB-1:0] * inner_radius_q[CB-1:0];
		ro_sq_q <= outer_radius_q[CB-1:0] * outer_radius_q[CB-1:0];
	end

	// A stage may load when it is empty or when the stage after it loads.
	assign en_w[D] = !v_q[D] || !out_stall;
	for (genvar k = 1; k < D; k++) begin : g_en
		assign en_w[k] = !v_q[k] || en_w[k+1];
	end

	assign v_in = {v_q[D-1:1], in_valid};
	assign in_stall = !en_w[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= D; k++) begin
				if (en_w[k]) begin
					v_q[k] <= v_in[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_w[1]) begin
			dx_s1 <= $signed({1'b0, x_coord[CB-1:0]}) - $signed({1'b0, center_x_q[CB-1:0]});
			dy_s1 <= $signed({1'b0, y_coord[CB-1:0]}) - $signed({1'b0, center_y_q[CB-1:0]});
			side_s[1] <= '{hit: 1'b0, red: background_red, green: background_green,
				blue: background_blue};
		end
	end

	assign dx_prod = dx_s1 * dx_s1;
	assign dy_prod = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		if (en_w[2]) begin
			dxsq_s2 <= dx_prod[2*CB:0];
			dysq_s2 <= dy_prod[2*CB:0];
		end
	end

	assign d2 = {1'b0, dxsq_s2} + {1'b0, dysq_s2};

	for (genvar k = 2; k < D; k++) begin : g_side
		if (k == 3) begin : g_hit
			always_ff @(posedge clk) begin
				if (en_w[k]) begin
					side_s[k] <= '{hit: (d2 > {2'b00, ri_sq_q}) && (d2 < {2'b00, ro_sq_q}),
						red: side_s[k-1].red, green: side_s[k-1].green,
						blue: side_s[k-1].blue};
				end
			end
		end else begin : g_copy
			always_ff @(posedge clk) begin
				if (en_w[k]) begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	rash_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES),
		.COORD_BITS(COORD_BITS)
	) u_cordic (
		.clk(clk),
		.en(en_w[CS+1:2]),
		.dx(dx_s1),
		.dy(dy_s1),
		.start_angle(start_angle_q),
		.gray(gray)
	);

	always_ff @(posedge clk) begin
		if (en_w[D]) begin
			ring_hit_q <= side_s[D-1].hit;
			if (!side_s[D-1].hit) begin
				out_red_q <= side_s[D-1].red;
				out_green_q <= side_s[D-1].green;
				out_blue_q <= side_s[D-1].blue;
			end else if (shade_mode_q == SHADE_SOLID) begin
				out_red_q <= solid_color_q[47:32];
				out_green_q <= solid_color_q[31:16];
				out_blue_q <= solid_color_q[15:0];
			end else begin
				out_red_q <= gray;
				out_green_q <= gray;
				out_blue_q <= gray;
			end
		end
	end

	assign out_valid = v_q[D];
	assign ring_hit = ring_hit_q;
	assign out_red = out_red_q;
	assign out_green = out_green_q;
	assign out_blue = out_blue_q;

	`RASH_ASSERT_IMP(a_stall_means_full, in_stall, (&v_q) && out_stall)
	`RASH_ASSERT_NXT(a_accept_lands, in_valid && !in_stall, v_q[1])
	`RASH_ASSERT_IMP(a_out_from_pipe, $rose(out_valid), $past(v_q[D-1]))

endmodule

// ===== test/ring_angle_shader_checker.sv =====
`timescale 1ns / 1ps
// Checker for ring_angle_shader_unit: tracks register writes, predicts the shaded color of
// every pixel transfer and compares it with each result transfer in order.
// Depends on rash_pkg for the register index and shade mode names.
module ring_angle_shader_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] x_coord,
	input  logic [15:0] y_coord,
	input  logic [15:0] background_red,
	input  logic [15:0] background_green,
	input  logic [15:0] background_blue,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        ring_hit,
	input  logic [15:0] out_red,
	input  logic [15:0] out_green,
	input  logic [15:0] out_blue,
	output int          fail_count,
	output int          pending_results
);
	import rash_pkg::*;

	localparam int ROT_STAGES = 16;
	localparam int VEC_SCALE = 24;
	localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
	localparam logic [31:0] TURN_HALF = 32'h8000_0000;
	localparam logic [31:0] TURN_THREE_QUARTER = 32'hC000_0000;

	typedef struct packed {
		logic        hit;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} pixel_color_t;

	logic [15:0] ctr_x, ctr_y, rad_in, rad_out, start_dir;
	shade_mode_t mode_q;
	logic [47:0] fill_color;
	pixel_color_t color_q [$];

	function automatic logic [31:0] arctan_step(input int i);
		case (i)
			0: return 32'h20000000;
			1: return 32'h12E4051E;
			2: return 32'h09FB385B;
			3: return 32'h051111D4;
			4: return 32'h028B0D43;
			5: return 32'h0145D7E1;
			6: return 32'h00A2F61E;
			7: return 32'h00517C55;
			8: return 32'h0028BE53;
			9: return 32'h00145F2F;
			10: return 32'h000A2F98;
			11: return 32'h000517CC;
			12: return 32'h00028BE6;
			13: return 32'h000145F3;
			14: return 32'h0000A2FA;
			15: return 32'h0000517D;
			16: return 32'h000028BE;
			17: return 32'h0000145F;
			18: return 32'h00000A30;
			19: return 32'h00000518;
			20: return 32'h0000028C;
			21: return 32'h00000146;
			22: return 32'h000000A3;
			default: return 32'h00000051;
		endcase
	endfunction

	function automatic logic [31:0] turn_from_start(input longint dx, input longint dy);
		longint vx, vy, nx, ny;
		logic [31:0] z, acc;
		int i;
		vx = dx <<< VEC_SCALE;
		vy = dy <<< VEC_SCALE;
		z = 32'd0 - {start_dir, 16'd0};
		if (z > TURN_QUARTER && z < TURN_THREE_QUARTER) begin
			vx = -vx;
			vy = -vy;
			z = z - TURN_HALF;
		end
		for (i = 0; i < ROT_STAGES; i++) begin
			if (z < TURN_HALF) begin
				nx = vx - (vy >>> i);
				ny = vy + (vx >>> i);
				z = z - arctan_step(i);
			end else begin
				nx = vx + (vy >>> i);
				ny = vy - (vx >>> i);
				z = z + arctan_step(i);
			end
			vx = nx;
			vy = ny;
		end
		acc = '0;
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			acc = TURN_HALF;
		end
		for (i = 0; i < ROT_STAGES; i++) begin
			if (vy >= 0) begin
				nx = vx + (vy >>> i);
				ny = vy - (vx >>> i);
				acc = acc + arctan_step(i);
			end else begin
				nx = vx - (vy >>> i);
				ny = vy + (vx >>> i);
				acc = acc - arctan_step(i);
			end
			vx = nx;
			vy = ny;
		end
		if (acc > TURN_HALF)
			acc = 32'd0 - acc;
		return acc;
	endfunction

	function automatic pixel_color_t shade_pixel(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] r, input logic [15:0] g, input logic [15:0] b);
		longint dx, dy, d2, ri, ro;
		logic [31:0] turn;
		logic [16:0] level;
		pixel_color_t res;
		dx = longint'(x) - longint'(ctr_x);
		dy = longint'(y) - longint'(ctr_y);
		d2 = dx * dx + dy * dy;
		ri = longint'(rad_in);
		ro = longint'(rad_out);
		res.hit = (d2 > ri * ri) && (d2 < ro * ro);
		if (!res.hit) begin
			res.red = r;
			res.green = g;
			res.blue = b;
		end else if (mode_q == SHADE_SOLID) begin
			res.red = fill_color[47:32];
			res.green = fill_color[31:16];
			res.blue = fill_color[15:0];
		end else begin
			level = '0;
			if (dx != 0 || dy != 0) begin
				turn = turn_from_start(dx, dy);
				level = turn[31:15];
			end
			if (level > 17'd65535)
				level = 17'd65535;
			res.red = level[15:0];
			res.green = level[15:0];
			res.blue = level[15:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_color_t want;
		if (!arst_n) begin
			ctr_x = 16'd32768;
			ctr_y = 16'd32768;
			rad_in = 16'd26214;
			rad_out = 16'd26870;
			start_dir = 16'd8192;
			mode_q = SHADE_ANGLE;
			fill_color = 48'hFFFF_0000_0000;
			color_q.delete();
			fail_count = 0;
			pending_results = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (color_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result transfer with none pending: hit=%0d rgb=%h %h %h",
							$realtime, ring_hit, out_red, out_green, out_blue);
				end else begin
					want = color_q.pop_front();
					if (ring_hit !== want.hit || out_red !== want.red
							|| out_green !== want.green || out_blue !== want.blue) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch: expected hit=%0d rgb=%h %h %h, got hit=%0d rgb=%h %h %h",
								$realtime, want.hit, want.red, want.green, want.blue,
								ring_hit, out_red, out_green, out_blue);
					end
				end
			end
			if (in_valid && !in_stall)
				color_q = {color_q, shade_pixel(x_coord, y_coord, background_red,
					background_green, background_blue)};
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_CENTER_X: ctr_x = cfg_wdata[15:0];
					REG_CENTER_Y: ctr_y = cfg_wdata[15:0];
					REG_INNER_RADIUS: rad_in = cfg_wdata[15:0];
					REG_OUTER_RADIUS: rad_out = cfg_wdata[15:0];
					REG_START_ANGLE: start_dir = cfg_wdata[15:0];
					REG_SHADE_MODE: mode_q = shade_mode_t'(cfg_wdata[0]);
					REG_SOLID_COLOR: fill_color = cfg_wdata;
					default: ;
				endcase
			end
			pending_results = color_q.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for ring_angle_shader_unit: clock, reset, register setups and pixel traffic
// with random idling on both channels. Depends on rash_pkg and ring_angle_shader_checker.
module tb_top;
	import rash_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] r_in;
		logic [15:0] r_out;
		logic [15:0] start;
		shade_mode_t mode;
		logic [47:0] color;
	} ring_setup_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [47:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] x_coord = '0;
	logic [15:0] y_coord = '0;
	logic [15:0] background_red = '0;
	logic [15:0] background_green = '0;
	logic [15:0] background_blue = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        ring_hit;
	logic [15:0] out_red, out_green, out_blue;
	int          fail_count, pending_results;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	ring_setup_t setup;

	ring_angle_shader_unit dut (.*);

	ring_angle_shader_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	initial begin
		#5_000_000;
		$display("[ring_angle_shader_unit] ERROR");
		$finish;
	end

	task automatic send_pixel(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] r, input logic [15:0] g, input logic [15:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		x_coord <= x;
		y_coord <= y;
		background_red <= r;
		background_green <= g;
		background_blue <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_at(input logic [15:0] x, input logic [15:0] y);
		send_pixel(x, y, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	task automatic apply_setup(input ring_setup_t s);
		drain_results();
		write_reg(REG_CENTER_X, {32'($urandom), s.cx});
		write_reg(REG_CENTER_Y, {32'($urandom), s.cy});
		write_reg(REG_INNER_RADIUS, {32'($urandom), s.r_in});
		write_reg(REG_OUTER_RADIUS, {32'($urandom), s.r_out});
		write_reg(REG_START_ANGLE, {32'($urandom), s.start});
		write_reg(REG_SHADE_MODE, {32'($urandom), 15'($urandom), s.mode});
		write_reg(REG_SOLID_COLOR, s.color);
		write_reg(REG_UNUSED, {32'($urandom), 16'($urandom)});
		cfg_wr_en <= 1'b0;
		setup = s;
	endtask

	function automatic ring_setup_t make_setup(input logic [15:0] cx, input logic [15:0] cy,
			input logic [15:0] r_in, input logic [15:0] r_out, input logic [15:0] start,
			input shade_mode_t mode, input logic [47:0] color);
		ring_setup_t s;
		s.cx = cx;
		s.cy = cy;
		s.r_in = r_in;
		s.r_out = r_out;
		s.start = start;
		s.mode = mode;
		s.color = color;
		return s;
	endfunction

	function automatic ring_setup_t random_setup();
		ring_setup_t s;
		int ro;
		s.cx = 16'($urandom);
		s.cy = 16'($urandom);
		s.r_in = 16'($urandom_range(20000));
		ro = int'(s.r_in) + int'($urandom_range(30000, 1));
		s.r_out = (ro > 65535) ? 16'hFFFF : 16'(ro);
		s.start = 16'($urandom);
		s.mode = ($urandom_range(3) == 0) ? SHADE_SOLID : SHADE_ANGLE;
		s.color = {32'($urandom), 16'($urandom)};
		case ($urandom_range(7))
			0: begin
				s.cx = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				s.cy = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				s.r_out = 16'hFFFF;
			end
			1: s.r_in = 16'h0000;
			2: s.r_in = s.r_out + 16'($urandom_range(1));
			3: s.start = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			4: s.start = $urandom_range(1) ? 16'h8000 : 16'h4000;
			default: ;
		endcase
		return s;
	endfunction

	function automatic logic [15:0] near_coord(input logic [15:0] c, input logic [15:0] span);
		int v;
		v = int'(c) + int'($urandom_range(2 * int'(span))) - int'(span);
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	initial begin
		logic [15:0] px, py;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_at(16'd59268, 16'd32768);
		send_at(16'd32768, 16'd59268);
		send_at(16'd6268, 16'd32768);
		send_at(16'd14030, 16'd14030);
		send_at(16'd32768, 16'd32768);
		send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

		apply_setup(make_setup(16'd32768, 16'd32768, 16'd1000, 16'd20000, 16'd0,
			SHADE_ANGLE, 48'h0));
		send_at(16'd37768, 16'd32768);
		send_at(16'd27768, 16'd32768);
		send_at(16'd32768, 16'd37768);
		send_at(16'd32768, 16'd27768);
		send_at(16'd33768, 16'd32768);
		send_at(16'd52768, 16'd32768);
		send_at(16'd52767, 16'd32768);
		send_at(16'd33769, 16'd32768);

		apply_setup(make_setup(16'd32768, 16'd32768, 16'd1000, 16'd20000, 16'd0,
			SHADE_SOLID, 48'h1234_5678_9ABC));
		send_at(16'd37768, 16'd32768);
		send_at(16'd0, 16'd0);

		apply_setup(make_setup(16'd32768, 16'd32768, 16'd20000, 16'd20000, 16'd16384,
			SHADE_ANGLE, 48'hFFFF_FFFF_FFFF));
		send_at(16'd37768, 16'd32768);
		send_at(16'd32768, 16'd45000);

		apply_setup(make_setup(16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535,
			SHADE_ANGLE, 48'h0));
		send_at(16'd1, 16'd0);
		send_at(16'd0, 16'd1);
		send_at(16'd65535, 16'd0);
		send_at(16'd0, 16'd65535);
		send_at(16'd65535, 16'd65535);
		send_at(16'd0, 16'd0);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 50 : 0;
			recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 32 : 0;
			for (int k = 0; k < 5; k++) begin
				apply_setup(random_setup());
				for (int n = 0; n < 50; n++) begin
					if ($urandom_range(9) < 6) begin
						px = near_coord(setup.cx, setup.r_out);
						py = near_coord(setup.cy, setup.r_out);
					end else begin
						px = 16'($urandom);
						py = 16'($urandom);
					end
					if ($urandom_range(15) == 0)
						send_pixel(px, py, 16'hFFFF, 16'h0000, 16'hFFFF);
					else
						send_at(px, py);
				end
			end
		end

		drain_results();
		repeat (40) @(negedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("[ring_angle_shader_unit] OK");
		else
			$display("[ring_angle_shader_unit] ERROR");
		$finish;
	end

endmodule
